// ----- src/sfla_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the sorted free-list allocator.
// No dependencies; sfla_cell and the top module import this package.
package sfla_pkg;

    localparam int HOLE_ENTRIES_DEF = 64;
    localparam int ADDR_W = 32;

    localparam logic [ADDR_W-1:0] PAGE_ADD  = 32'h0000_0fff;
    localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hffff_f000;

    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NO_MEM = 2'd1;
    localparam logic [1:0] STAT_LOST   = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ALLOC,
        OP_MERGE_BOTH,
        OP_MERGE_PREV,
        OP_MERGE_NEXT,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     drop;
    } cell_cmd_t;

    typedef struct packed {
        logic fit;
        logic exact;
        logic gt;
        logic end_hit;
        logic start_hit;
    } hole_flags_t;

endpackage

// ----- src/sfla_pick.sv -----
`timescale 1ns / 1ps
// Find-first-set over a flag vector: one-hot of the lowest set bit and a
// mask of every position above it. Depends on nothing.
module sfla_pick #(
    parameter int W = 8
) (
    input  logic [W-1:0] vec,
    output logic [W-1:0] first,
    output logic [W-1:0] above,
    output logic         any
);

    // Isolate the lowest set bit.
    assign first = vec & (~vec + {{(W-1){1'b0}}, 1'b1});
    // Bits below the first are first - 1; everything else but first is above.
    assign above = ~(first | (first - {{(W-1){1'b0}}, 1'b1}));
    assign any   = |vec;

endmodule

// ----- src/sfla_cell.sv -----
`timescale 1ns / 1ps
// One hole slot of the sorted chain: holds base and length, probes them
// against the request, and shifts to or from its neighbors. Uses sfla_pkg.
module sfla_cell import sfla_pkg::*; (
    input  logic              clk,
    input  logic              probe,
    input  logic              apply,
    input  cell_cmd_t         cmd,
    input  logic              hit,
    input  logic              above,
    input  logic [ADDR_W-1:0] req_addr,
    input  logic [ADDR_W-1:0] req_size,
    input  logic [ADDR_W-1:0] req_end,
    input  logic [ADDR_W-1:0] prev_base,
    input  logic [ADDR_W-1:0] prev_len,
    input  logic [ADDR_W-1:0] next_base,
    input  logic [ADDR_W-1:0] next_len,
    output logic [ADDR_W-1:0] base,
    output logic [ADDR_W-1:0] len,
    output hole_flags_t       flags
);

    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    hole_flags_t       flags_reg, flags_next;

    always_comb
    begin
        flags_next.fit       = (len_reg >= req_size);
        flags_next.exact     = (len_reg == req_size);
        flags_next.gt        = (base_reg > req_addr);
        flags_next.end_hit   = ((base_reg + len_reg) == req_addr);
        flags_next.start_hit = (req_end == base_reg);
    end

    always_comb
    begin
        base_next = base_reg;
        len_next  = len_reg;
        case (cmd.op)
            OP_ALLOC:
            begin
                if (cmd.drop && (hit || above))
                begin
                    base_next = next_base;
                    len_next  = next_len;
                end
                else if (hit)
                begin
                    base_next = base_reg + req_size;
                    len_next  = len_reg - req_size;
                end
            end
            OP_MERGE_BOTH:
            begin
                if (hit)
                begin
                    len_next = len_reg + req_size + next_len;
                end
                else if (above)
                begin
                    base_next = next_base;
                    len_next  = next_len;
                end
            end
            OP_MERGE_PREV:
            begin
                if (hit)
                begin
                    len_next = len_reg + req_size;
                end
            end
            OP_MERGE_NEXT:
            begin
                if (hit)
                begin
                    base_next = req_addr;
                    len_next  = len_reg + req_size;
                end
            end
            OP_INSERT:
            begin
                if (hit)
                begin
                    base_next = req_addr;
                    len_next  = req_size;
                end
                else if (above)
                begin
                    base_next = prev_base;
                    len_next  = prev_len;
                end
            end
            default:
            begin
                base_next = base_reg;
                len_next  = len_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (probe)
        begin
            flags_reg <= flags_next;
        end
        if (apply)
        begin
            base_reg <= base_next;
            len_reg  <= len_next;
        end
    end

    assign base  = base_reg;
    assign len   = len_reg;
    assign flags = flags_reg;

endmodule

// ----- src/sorted_free_list_allocator.sv -----
`timescale 1ns / 1ps
// First-fit free-list allocator with coalescing, built as a chain of hole cells.
// Each item passes a probe state, where every cell compares its hole against the
// request, and an apply state that waits for a free output slot, picks the first
// matching cell and, when a hole is dropped or inserted, shifts the chain by one
// slot. A new item is taken when idle or as the current one retires. Reset
// (rst_n, async, active low) clears hole count and statistics, not hole storage.
module sorted_free_list_allocator import sfla_pkg::*; #(
    parameter  int HOLE_ENTRIES = HOLE_ENTRIES_DEF,
    localparam int CNT_W        = $clog2(HOLE_ENTRIES + 1),
    localparam int M_RAW        = 4 * ADDR_W + 2 * CNT_W,
    localparam int M_W          = ((M_RAW + 7) / 8) * 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    // block_address[31:0], request_size[63:32], page_round[64], zero fill
    input  logic [71:0]    s_tdata,
    // opcode[0]
    input  logic           s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    // granted_address, total_free, holes_now, holes_max, lost_free_count,
    // lost_free_bytes, low bits first, zero fill
    output logic [M_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]     m_tuser
);

    localparam int N = HOLE_ENTRIES;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Request held for the probe and apply cycles.
    logic              opc_reg;
    logic [ADDR_W-1:0] addr_reg, size_reg, end_reg;
    logic [ADDR_W-1:0] size_in;

    // Statistics.
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;
    logic [ADDR_W-1:0] free_sum_reg, free_sum_next;
    logic [ADDR_W-1:0] lost_cnt_reg, lost_cnt_next;
    logic [ADDR_W-1:0] lost_bytes_reg, lost_bytes_next;

    // Output slot.
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] granted_reg;
    logic [1:0]        status_reg;
    logic [ADDR_W-1:0] out_free_reg, out_lost_cnt_reg, out_lost_bytes_reg;
    logic [CNT_W-1:0]  out_used_reg, out_peak_reg;

    logic accept, out_free, finish;

    // Chain wiring.
    logic [N-1:0][ADDR_W-1:0] cell_base, cell_len;
    hole_flags_t [N-1:0]      cell_flags;
    logic [N-1:0]             occ, fit_v, exact_v;
    logic [N:0]               pos_req, pos_oh, pos_above;
    logic                     pos_any;
    logic [N-1:0]             f_oh, f_above;
    logic                     f_any;
    logic [N-1:0]             hit_v, above_v, tgt_first;
    logic                     tgt_any;
    logic                     prev_merge, next_merge, not_full, drop;
    logic [ADDR_W-1:0]        granted_next;
    logic [1:0]               status_next;
    cell_cmd_t                cmd, cell_cmd;

    // ------------------------------------------------------------------
    // Handshake and sequencing
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_tready;
    assign finish   = (state_reg == ST_APPLY) && out_free;
    // Take a new item while idle, or in the same cycle the current one retires.
    assign s_tready = (state_reg == ST_IDLE) || finish;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = accept ? ST_PROBE : ST_IDLE;
            ST_PROBE: state_next = ST_APPLY;
            ST_APPLY:
            begin
                if (finish)
                begin
                    state_next = accept ? ST_PROBE : ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Page round-up wraps mod 2^32.
    assign size_in = s_tdata[64] ? ((s_tdata[63:32] + PAGE_ADD) & PAGE_MASK)
                                 : s_tdata[63:32];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opc_reg  <= s_tuser;
            addr_reg <= s_tdata[31:0];
            size_reg <= size_in;
            end_reg  <= s_tdata[31:0] + size_in;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        logic [ADDR_W-1:0] pb, pl, nb, nl;

        if (k == 0)
        begin : g_first
            assign pb = '0;
            assign pl = '0;
        end
        else
        begin : g_mid_lo
            assign pb = cell_base[k-1];
            assign pl = cell_len[k-1];
        end

        if (k == N - 1)
        begin : g_last
            assign nb = '0;
            assign nl = '0;
        end
        else
        begin : g_mid_hi
            assign nb = cell_base[k+1];
            assign nl = cell_len[k+1];
        end

        sfla_cell u_cell (
            .clk       (clk),
            .probe     (state_reg == ST_PROBE),
            .apply     (finish),
            .cmd       (cell_cmd),
            .hit       (hit_v[k]),
            .above     (above_v[k]),
            .req_addr  (addr_reg),
            .req_size  (size_reg),
            .req_end   (end_reg),
            .prev_base (pb),
            .prev_len  (pl),
            .next_base (nb),
            .next_len  (nl),
            .base      (cell_base[k]),
            .len       (cell_len[k]),
            .flags     (cell_flags[k])
        );

        // Only cells below the fill count hold live holes.
        assign occ[k]     = (CNT_W'(k) < used_reg);
        assign fit_v[k]   = cell_flags[k].fit & occ[k];
        assign exact_v[k] = cell_flags[k].exact;
        // Insert position: first live hole above the address, else the fill count.
        assign pos_req[k] = (cell_flags[k].gt & occ[k]) | (CNT_W'(k) == used_reg);
    end

    assign pos_req[N] = (CNT_W'(N) == used_reg);

    sfla_pick #(.W(N)) u_pick_fit (
        .vec   (fit_v),
        .first (f_oh),
        .above (f_above),
        .any   (f_any)
    );

    sfla_pick #(.W(N + 1)) u_pick_pos (
        .vec   (pos_req),
        .first (pos_oh),
        .above (pos_above),
        .any   (pos_any)
    );

    // Merge checks look only at the neighbors of the insert position.
    always_comb
    begin
        prev_merge = 1'b0;
        next_merge = 1'b0;
        granted_next = '0;
        for (int k = 0; k < N; k++)
        begin
            prev_merge = prev_merge | (pos_oh[k+1] & cell_flags[k].end_hit);
            next_merge = next_merge | (pos_oh[k] & occ[k] & cell_flags[k].start_hit);
            granted_next = granted_next | (cell_base[k] & {ADDR_W{f_oh[k]}});
        end
    end

    assign not_full = (used_reg < CNT_W'(N));
    assign drop     = |(f_oh & exact_v);

    // Pick the chain operation and its target cell.
    always_comb
    begin
        cmd.op      = OP_NONE;
        cmd.drop    = 1'b0;
        hit_v       = '0;
        status_next = STAT_OK;
        if (opc_reg == OPC_ALLOC)
        begin
            if (f_any)
            begin
                cmd.op   = OP_ALLOC;
                cmd.drop = drop;
                hit_v    = f_oh;
            end
            else
            begin
                status_next = STAT_NO_MEM;
            end
        end
        else if (prev_merge && next_merge)
        begin
            cmd.op = OP_MERGE_BOTH;
            hit_v  = pos_oh[N:1];
        end
        else if (prev_merge)
        begin
            cmd.op = OP_MERGE_PREV;
            hit_v  = pos_oh[N:1];
        end
        else if (next_merge)
        begin
            cmd.op = OP_MERGE_NEXT;
            hit_v  = pos_oh[N-1:0];
        end
        else if (not_full)
        begin
            cmd.op = OP_INSERT;
            hit_v  = pos_oh[N-1:0];
        end
        else
        begin
            status_next = STAT_LOST;
        end
    end

    sfla_pick #(.W(N)) u_pick_tgt (
        .vec   (hit_v),
        .first (tgt_first),
        .above (above_v),
        .any   (tgt_any)
    );

    // Hold the chain unless the item retires this cycle.
    always_comb
    begin
        cell_cmd = cmd;
        if (!finish || !tgt_any)
        begin
            cell_cmd.op = OP_NONE;
        end
    end

    // ------------------------------------------------------------------
    // Statistics
    // ------------------------------------------------------------------
    always_comb
    begin
        used_next       = used_reg;
        free_sum_next   = free_sum_reg;
        lost_cnt_next   = lost_cnt_reg;
        lost_bytes_next = lost_bytes_reg;
        case (cmd.op)
            OP_ALLOC:
            begin
                free_sum_next = free_sum_reg - size_reg;
                if (cmd.drop)
                begin
                    used_next = used_reg - CNT_W'(1);
                end
            end
            OP_MERGE_BOTH:
            begin
                free_sum_next = free_sum_reg + size_reg;
                used_next     = used_reg - CNT_W'(1);
            end
            OP_MERGE_PREV, OP_MERGE_NEXT:
            begin
                free_sum_next = free_sum_reg + size_reg;
            end
            OP_INSERT:
            begin
                free_sum_next = free_sum_reg + size_reg;
                used_next     = used_reg + CNT_W'(1);
            end
            default:
            begin
                if (status_next == STAT_LOST)
                begin
                    lost_cnt_next   = lost_cnt_reg + ADDR_W'(1);
                    lost_bytes_next = lost_bytes_reg + size_reg;
                end
            end
        endcase
        peak_next = (used_next > peak_reg) ? used_next : peak_reg;
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (finish)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            used_reg       <= '0;
            peak_reg       <= '0;
            free_sum_reg   <= '0;
            lost_cnt_reg   <= '0;
            lost_bytes_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (finish)
            begin
                used_reg       <= used_next;
                peak_reg       <= peak_next;
                free_sum_reg   <= free_sum_next;
                lost_cnt_reg   <= lost_cnt_next;
                lost_bytes_reg <= lost_bytes_next;
            end
        end
    end

    // Load the output slot when the item retires.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            granted_reg        <= (cmd.op == OP_ALLOC) ? granted_next : '0;
            status_reg         <= status_next;
            out_free_reg       <= free_sum_next;
            out_used_reg       <= used_next;
            out_peak_reg       <= peak_next;
            out_lost_cnt_reg   <= lost_cnt_next;
            out_lost_bytes_reg <= lost_bytes_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_W - M_RAW){1'b0}}, out_lost_bytes_reg, out_lost_cnt_reg,
                       out_peak_reg, out_used_reg, out_free_reg, granted_reg};

endmodule
